// File: src/spectral_centroid_flux_defines.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef SPECTRAL_CENTROID_FLUX_DEFINES_SVH
`define SPECTRAL_CENTROID_FLUX_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SCF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
// implication checked on the next clock edge
`define SCF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

// File: src/scf_pkg.sv
// Shared types and constants for the spectral centroid / flux block.
// No dependencies.
package scf_pkg;
	localparam int FftSize = 4096;
	localparam int SampleWidth = 24;
	localparam int Bins = FftSize / 2;
	localparam int BinIdxW = $clog2(Bins);
	localparam int BinCntW = $clog2(Bins + 2);
	localparam int MagW = 24;
	localparam int SqW = 2 * SampleWidth + 1;
	localparam int WsumW = 45;
	localparam int SumW = 35;
	localparam int CenW = 20;
	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);

	// work item between the front and back parts
	typedef struct packed {
		logic [SampleWidth-1:0] re_abs;
		logic [SampleWidth-1:0] im_abs;
		logic                   use_bin;
		logic [BinCntW-1:0]     bin;
		logic                   last;
	} scf_item_t;

	typedef enum logic [2:0] {
		B_IDLE, B_SQRT, B_RDMEM, B_ACC, B_DIV, B_OUT
	} back_state_t;
endpackage

// File: src/scf_front.sv
// Front part: accepts bins, takes absolute values, tracks bin index, feeds queue.
// Depends on scf_pkg.
module scf_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [2*scf_pkg::SampleWidth-1:0]    in_data,
	input  logic                                 in_last,
	output logic                                 q_valid,
	input  logic                                 q_ready,
	output scf_pkg::scf_item_t                   q_item
);
	scf_pkg::scf_item_t mem_q [scf_pkg::QDepth];
	logic [scf_pkg::QPtrW:0] wp_q, rp_q;
	logic [scf_pkg::BinCntW-1:0] bin_q;
	logic push, pop;
	logic [scf_pkg::SampleWidth-1:0] re, im;
	scf_pkg::scf_item_t nw;

	function automatic logic [scf_pkg::SampleWidth-1:0] absv(
		input logic [scf_pkg::SampleWidth-1:0] v);
		absv = v[scf_pkg::SampleWidth-1] ? (~v + 1'b1) : v;
	endfunction

	assign re = in_data[scf_pkg::SampleWidth-1:0];
	assign im = in_data[2*scf_pkg::SampleWidth-1:scf_pkg::SampleWidth];
	assign in_ready = (wp_q - rp_q) != (scf_pkg::QPtrW+1)'(scf_pkg::QDepth);
	assign q_valid = wp_q != rp_q;
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q[scf_pkg::QPtrW-1:0]];

	always_comb begin
		nw.re_abs = absv(re);
		nw.im_abs = absv(im);
		nw.use_bin = bin_q <= scf_pkg::BinCntW'(scf_pkg::Bins);
		nw.bin = bin_q;
		nw.last = in_last;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q[scf_pkg::QPtrW-1:0]] <= nw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			bin_q <= scf_pkg::BinCntW'(1);
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
				// advance, hold past the last bin, restart at frame end
				if (in_last) bin_q <= scf_pkg::BinCntW'(1);
				else if (nw.use_bin) bin_q <= bin_q + 1'b1;
			end
			if (pop) rp_q <= rp_q + 1'b1;
		end
	end
endmodule

// File: src/scf_back.sv
// Back part: square root, previous-magnitude memory, sums, centroid divide.
// Depends on scf_pkg.
module scf_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  scf_pkg::scf_item_t              q_item,
	input  logic [scf_pkg::SumW-1:0]        min_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [scf_pkg::CenW-1:0]        out_cen,
	output logic [scf_pkg::SumW-1:0]        out_flux
);
	localparam int SqIt = scf_pkg::SqW / 2 + 1;
	localparam int DvW = scf_pkg::WsumW + 8;
	localparam logic [scf_pkg::WsumW-1:0] WMax = '1;
	localparam logic [scf_pkg::SumW-1:0] SMax = '1;

	scf_pkg::back_state_t st_q, st_d;
	scf_pkg::scf_item_t it_q;
	logic [scf_pkg::SqW-1:0] x_q, res_q, bit_q;
	logic [5:0] cnt_q;
	logic [scf_pkg::MagW-1:0] mem [scf_pkg::Bins];
	logic [scf_pkg::MagW-1:0] prev_q, mag;
	logic [scf_pkg::BinIdxW:0] clr_q;
	logic clr_busy;
	logic out_free;
	logic [scf_pkg::WsumW-1:0] wsum_q;
	logic [scf_pkg::SumW-1:0] msum_q, rsum_q;
	logic [DvW-1:0] quo_q;
	logic [scf_pkg::SumW:0] rem_q;
	logic [scf_pkg::CenW-1:0] cen_q;
	logic [scf_pkg::SumW-1:0] flux_q;
	logic [scf_pkg::SqW-1:0] trial;
	logic [scf_pkg::BinIdxW-1:0] slot;
	logic [scf_pkg::WsumW:0] wadd;
	logic [scf_pkg::WsumW-1:0] wnext;
	logic [scf_pkg::SumW:0] madd, radd;
	logic [scf_pkg::BinCntW+scf_pkg::MagW-1:0] prod;
	logic [scf_pkg::SumW:0] rtry;
	logic [DvW-1:0] dividend;

	assign mag = res_q[scf_pkg::MagW-1:0];
	assign slot = scf_pkg::BinIdxW'(it_q.bin - 1'b1);
	assign trial = res_q | bit_q;
	assign prod = it_q.bin * mag;
	assign wadd = {1'b0, wsum_q} + (scf_pkg::WsumW+1)'(prod);
	assign wnext = !it_q.use_bin ? wsum_q
		: (wadd[scf_pkg::WsumW] ? WMax : wadd[scf_pkg::WsumW-1:0]);
	assign madd = {1'b0, msum_q} + (scf_pkg::SumW+1)'(mag);
	assign radd = {1'b0, rsum_q} + (scf_pkg::SumW+1)'(mag - prev_q);
	// divide the weighted sum that includes the current bin
	assign dividend = {wnext, 8'd0};
	assign rtry = {rem_q[scf_pkg::SumW-1:0], quo_q[DvW-1]};
	assign clr_busy = !clr_q[scf_pkg::BinIdxW];
	assign out_free = !out_valid || out_ready;
	assign out_cen = cen_q;
	assign out_flux = flux_q;

	always_comb begin
		st_d = st_q;
		q_ready = 1'b0;
		unique case (st_q)
			scf_pkg::B_IDLE: begin
				q_ready = !clr_busy;
				if (q_valid && q_ready) st_d = scf_pkg::B_SQRT;
			end
			scf_pkg::B_SQRT: if (cnt_q == 6'(SqIt - 1)) st_d = scf_pkg::B_RDMEM;
			scf_pkg::B_RDMEM: st_d = scf_pkg::B_ACC;
			scf_pkg::B_ACC: st_d = it_q.last ? scf_pkg::B_DIV : scf_pkg::B_IDLE;
			scf_pkg::B_DIV: if (cnt_q == 6'(DvW - 1)) st_d = scf_pkg::B_OUT;
			// hold until the output word is free
			scf_pkg::B_OUT: if (out_free) st_d = scf_pkg::B_IDLE;
			default: st_d = scf_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (clr_busy) mem[clr_q[scf_pkg::BinIdxW-1:0]] <= '0;
		else if (st_q == scf_pkg::B_ACC && it_q.use_bin) mem[slot] <= mag;
		prev_q <= mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= scf_pkg::B_IDLE;
			clr_q <= '0;
			cnt_q <= '0;
			it_q <= '0;
			x_q <= '0;
			res_q <= '0;
			bit_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			cen_q <= '0;
			flux_q <= '0;
			wsum_q <= '0;
			msum_q <= '0;
			rsum_q <= '0;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (clr_busy) clr_q <= clr_q + 1'b1;
			if (st_q == scf_pkg::B_OUT && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (st_q)
				scf_pkg::B_IDLE: if (st_d == scf_pkg::B_SQRT) begin
					it_q <= q_item;
					x_q <= scf_pkg::SqW'(q_item.re_abs * q_item.re_abs)
						+ scf_pkg::SqW'(q_item.im_abs * q_item.im_abs);
					res_q <= '0;
					bit_q <= scf_pkg::SqW'(1) << (2 * (SqIt - 1));
					cnt_q <= '0;
				end
				scf_pkg::B_SQRT: begin
					// one result bit per cycle
					if (x_q >= trial) begin
						x_q <= x_q - trial;
						res_q <= (res_q >> 1) | bit_q;
					end else res_q <= res_q >> 1;
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 1'b1;
				end
				scf_pkg::B_RDMEM: ;
				scf_pkg::B_ACC: begin
					wsum_q <= wnext;
					if (it_q.use_bin) begin
						msum_q <= madd[scf_pkg::SumW] ? SMax : madd[scf_pkg::SumW-1:0];
						if (mag > prev_q)
							rsum_q <= radd[scf_pkg::SumW] ? SMax : radd[scf_pkg::SumW-1:0];
					end
					quo_q <= dividend;
					rem_q <= '0;
					cnt_q <= '0;
				end
				scf_pkg::B_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (rtry >= {1'b0, msum_q}) begin
						rem_q <= rtry - {1'b0, msum_q};
						quo_q <= {quo_q[DvW-2:0], 1'b1};
					end else begin
						rem_q <= rtry;
						quo_q <= {quo_q[DvW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
				end
				scf_pkg::B_OUT: if (out_free) begin
					if (msum_q > min_level && msum_q != '0)
						cen_q <= (|quo_q[DvW-1:scf_pkg::CenW]) ? '1
							: quo_q[scf_pkg::CenW-1:0];
					else cen_q <= '0;
					flux_q <= rsum_q;
					wsum_q <= '0;
					msum_q <= '0;
					rsum_q <= '0;
				end
				default: ;
			endcase
		end
	end
endmodule

// File: src/spectral_centroid_flux.sv
// Spectral centroid and flux over one frame of FFT bins, bins 1..2048 in order.
// In the back part a non-last bin is accepted, takes a 25-step square root, a
// memory read and an accumulate; a last bin adds the 53-step centroid divide and
// the output load, and waits there while the previous result word is still
// unaccepted. After reset a clearing pass over all 2048 entries zeroes the
// previous-magnitude memory before the first bin is processed; a 4-entry queue
// buffers input meanwhile.
// Depends on scf_pkg, scf_front, scf_back.
module spectral_centroid_flux (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // bin_real[23:0], bin_imag[47:24]
	input  logic        s_axis_tlast,  // last_in_frame
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // centroid_q8[19:0], flux_sum[54:20], zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [34:0] cfg_data
);
	logic [scf_pkg::SumW-1:0] min_q;
	logic q_valid, q_ready;
	scf_pkg::scf_item_t q_item;
	logic [scf_pkg::CenW-1:0] cen;
	logic [scf_pkg::SumW-1:0] flux;

	assign cfg_ready = 1'b1;
	assign m_axis_tdata = {1'b0, flux, cen};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_q <= '0;
		else if (cfg_valid) min_q <= cfg_data;
	end

	scf_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata), .in_last(s_axis_tlast),
		.q_valid, .q_ready, .q_item
	);

	scf_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.min_level(min_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_cen(cen), .out_flux(flux)
	);
endmodule

// File: src/scf_checker.sv
// Port-level checks for spectral_centroid_flux, bound to the top level.
// Depends on spectral_centroid_flux_defines.svh.
`include "spectral_centroid_flux_defines.svh"
module scf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        cfg_ready
);
	`SCF_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`SCF_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[55] == 1'b0)
	`SCF_ASSERT_IMP(a_cfg_rdy, 1'b1, cfg_ready)
endmodule

bind spectral_centroid_flux scf_checker u_chk (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_ready
);
